/* hdl/mtfd_pkg.sv */
package mtfd_pkg;

  // Fixed field widths of the item and result.
  localparam int SYM_W   = 8;
  localparam int ALPHA_W = 9;

  // Default number of list cells and reset alphabet size.
  localparam int          ALPHABET_DEF = 256;
  localparam logic [8:0]  ALPHA_RST    = 9'd256;

  // Action codes carried by an input item.
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_DECODE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_t;

  // Control broadcast from the sequencer to every list cell.
  typedef struct packed {
    logic             wr_en;
    logic             swap_en;
    logic [SYM_W-1:0] wr_data;
  } cell_ctl_t;

  // One result item.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             sym_vld;
    logic             err;
    logic             last;
  } res_t;

endpackage

/* hdl/mtfd_cell.sv */
module mtfd_cell #(
  parameter int ALPHABET = 256,
  parameter int IDX      = 0
) (
  input  logic                                clk,
  input  mtfd_pkg::cell_ctl_t                 ctl,
  input  logic [$clog2(ALPHABET)-1:0]         ptr,
  input  logic [$clog2(ALPHABET+1)-1:0]       wr_idx,
  input  logic [mtfd_pkg::SYM_W-1:0]          dn_val,
  input  logic [mtfd_pkg::SYM_W-1:0]          up_val,
  output logic [mtfd_pkg::SYM_W-1:0]          val
);
  import mtfd_pkg::*;

  localparam int PW     = $clog2(ALPHABET);
  localparam int CW     = $clog2(ALPHABET+1);
  localparam int IDX_UP = IDX + 1;

  logic [SYM_W-1:0] val_r;
  logic [SYM_W-1:0] val_nxt;
  logic             sel_wr;
  logic             sel_lo;
  logic             sel_hi;

  // Decode whether this cell is the append target or one side of the swap.
  assign sel_wr = ctl.wr_en && (wr_idx == CW'(IDX));
  assign sel_hi = ctl.swap_en && ((PW+1)'(ptr) == (PW+1)'(IDX));
  assign sel_lo = ctl.swap_en && ((PW+1)'(ptr) == (PW+1)'(IDX_UP));

  // The cell at the pointer takes its lower neighbor, the one below takes the upper.
  always_comb begin
    val_nxt = val_r;
    if (sel_wr) begin
      val_nxt = ctl.wr_data;
    end else if (sel_hi) begin
      val_nxt = dn_val;
    end else if (sel_lo) begin
      val_nxt = up_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

/* hdl/move_to_front_decoder_with_map_top.sv */
// Inverse move-to-front decoder with the symbol map folded into the initial list.
// The list lives in a chain of ALPHABET cells, one symbol per cell. Start, append,
// error and rank-0 items are answered from the idle state. For a rank r item (r > 0),
// the chosen entry moves toward the front one cell per cycle by swapping with its
// lower neighbor, so the length of that swap walk through the cell chain sets the
// rate. Results pass through one result register and one output register, so a new
// item can be taken while a finished result waits at the output. The list needs no
// clearing after reset; cells beyond the count are never read.
module move_to_front_decoder_with_map_top #(
  parameter int ALPHABET = mtfd_pkg::ALPHABET_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [mtfd_pkg::SYM_W-1:0]          in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mtfd_pkg::SYM_W-1:0]          out_symbol,
  output logic                                out_symbol_valid,
  output logic                                out_error,
  output logic                                out_last_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtfd_pkg::ALPHA_W-1:0]        cfg_data
);
  import mtfd_pkg::*;

  localparam int PW = $clog2(ALPHABET);
  localparam int CW = $clog2(ALPHABET+1);

  state_t             state_r, state_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  res_t               res_r, res_nxt;
  logic               res_vld_r, res_vld_nxt;
  res_t               out_r, out_nxt;
  logic               out_vld_r, out_vld_nxt;
  cell_ctl_t          ctl;
  logic               in_acc;
  logic               out_free;
  logic [SYM_W-1:0]   cell_q [ALPHABET];

  // The list cells, each wired to its two neighbors.
  for (genvar i = 0; i < ALPHABET; i++) begin : g_cell
    localparam int DN = (i == 0) ? 0 : i - 1;
    localparam int UP = (i == ALPHABET - 1) ? i : i + 1;
    mtfd_cell #(
      .ALPHABET(ALPHABET),
      .IDX     (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .ptr   (ptr_r),
      .wr_idx(count_r),
      .dn_val(cell_q[DN]),
      .up_val(cell_q[UP]),
      .val   (cell_q[i])
    );
  end

  // Handshakes. A staged result only blocks the input while it cannot move on.
  assign in_stall  = (state_r != ST_IDLE) || (res_vld_r && !out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_vld_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Sequencer: item decode, swap walk and result staging.
  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    count_nxt   = count_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r;
    ctl.wr_en   = 1'b0;
    ctl.swap_en = 1'b0;
    ctl.wr_data = in_value;
    alpha_nxt   = (cfg_valid && cfg_ready) ? cfg_data : alpha_r;

    if (res_vld_r && out_free) begin
      res_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt     = '0;
          res_vld_nxt = 1'b1;
          case (in_action)
            ACT_START: begin
              count_nxt = '0;
            end
            ACT_APPEND: begin
              if ((ALPHA_W'(in_value) >= alpha_r) || (count_r >= CW'(ALPHABET))) begin
                res_nxt.err = 1'b1;
              end else begin
                ctl.wr_en = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_DECODE: begin
              res_nxt.last = in_last;
              if (ALPHA_W'(in_value) >= ALPHA_W'(count_r)) begin
                res_nxt.err = 1'b1;
              end else if (in_value == '0) begin
                res_nxt.sym     = cell_q[0];
                res_nxt.sym_vld = 1'b1;
              end else begin
                // Walk the entry down to the front before reporting it.
                res_vld_nxt = 1'b0;
                ptr_nxt     = PW'(in_value);
                state_nxt   = ST_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        ctl.swap_en = 1'b1;
        ptr_nxt     = ptr_r - PW'(1);
        if (ptr_r == PW'(1)) begin
          res_nxt.sym     = cell_q[1];
          res_nxt.sym_vld = 1'b1;
          res_vld_nxt     = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (out_free) begin
      out_vld_nxt = res_vld_r;
      out_nxt     = res_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      res_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      alpha_r   <= ALPHA_RST;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      res_vld_r <= res_vld_nxt;
      out_vld_r <= out_vld_nxt;
      alpha_r   <= alpha_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_symbol       = out_r.sym;
  assign out_symbol_valid = out_r.sym_vld;
  assign out_error        = out_r.err;
  assign out_last_out     = out_r.last;

  // The list never holds more entries than there are cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ALPHABET))
    else $error("list count exceeds the number of cells");

  // A swap walk never runs with the pointer at the front cell.
  a_ptr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (ptr_r != '0))
    else $error("swap walk reached the front cell");

  // No staged result is pending while a walk is in progress.
  a_walk_res_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> !res_vld_r)
    else $error("result pending during swap walk");

  // The last swap step stages a decoded symbol.
  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SHIFT) && (ptr_r == PW'(1))) |=>
      (res_vld_r && res_r.sym_vld && (state_r == ST_IDLE)))
    else $error("swap walk ended without a decoded symbol");

endmodule

/* tb/move_to_front_decoder_with_map_top_tb.sv */
`timescale 1ns / 1ps

module move_to_front_decoder_with_map_top_tb;
  import mtfd_pkg::*;

  // Action code that the block answers with an empty result.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int LIST_DEPTH = ALPHABET_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 200;

  typedef struct packed {
    logic [1:0]       action;
    logic [SYM_W-1:0] value;
    logic             last;
  } mtf_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_START;
  logic [SYM_W-1:0]   in_value = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SYM_W-1:0]   out_symbol;
  logic               out_symbol_valid;
  logic               out_error;
  logic               out_last_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ALPHA_W-1:0] cfg_data = ALPHA_RST;

  // Items waiting to be sent and results waiting to be seen.
  mtf_item_t pending_items[$];
  res_t      expected_results[$];

  // Shadow copy of the list, its count and the alphabet size.
  logic [SYM_W-1:0] shadow_list[LIST_DEPTH];
  int               shadow_count = 0;
  int               shadow_alpha = ALPHA_RST;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  items_pushed = 0;

  move_to_front_decoder_with_map_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_symbol_valid (out_symbol_valid),
    .out_error        (out_error),
    .out_last_out     (out_last_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // Apply one item to the shadow list and return the result it should give.
  function automatic res_t mtf_predict(logic [1:0] action, logic [SYM_W-1:0] value,
                                       logic last);
    res_t             res;
    logic [SYM_W-1:0] picked;
    res = '0;
    case (action)
      ACT_START: begin
        shadow_count = 0;
      end
      ACT_APPEND: begin
        if (int'(value) >= shadow_alpha || shadow_count >= LIST_DEPTH) begin
          res.err = 1'b1;
        end else begin
          shadow_list[shadow_count] = value;
          shadow_count++;
        end
      end
      ACT_DECODE: begin
        res.last = last;
        if (int'(value) >= shadow_count) begin
          res.err = 1'b1;
        end else begin
          picked = shadow_list[value];
          for (int i = int'(value); i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = picked;
          res.sym = picked;
          res.sym_vld = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Sender: holds a stalled item, otherwise takes the next pending item or idles.
  always @(posedge clk) begin : send_proc
    mtf_item_t nxt;
    bit        taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        expected_results.push_back(mtf_predict(in_action, in_value, in_last));
      end
      if (!in_valid || taken) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid  <= 1'b1;
          in_action <= nxt.action;
          in_value  <= nxt.value;
          in_last   <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin : check_proc
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got symbol %0d valid %0b err %0b last %0b",
                 $time, out_symbol, out_symbol_valid, out_error, out_last_out);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("symbol", want.sym, out_symbol);
        check_field("symbol_valid", want.sym_vld, out_symbol_valid);
        check_field("error", want.err, out_error);
        check_field("last_out", want.last, out_last_out);
      end
    end
  end

  // Watchdog: counts cycles with work pending and no handshake at all.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (in_valid || cfg_valid || pending_items.size() > 0 ||
                 expected_results.size() > 0) begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("move_to_front_decoder_with_map_top regression: fail");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] action, logic [SYM_W-1:0] value, logic last);
    mtf_item_t it;
    it.action = action;
    it.value  = value;
    it.last   = last;
    pending_items.push_back(it);
    items_pushed++;
  endtask

  // Wait until every item is sent and every result has come back.
  task automatic drain_all();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_alpha(int size);
    drain_all();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size[ALPHA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    shadow_alpha = size;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // One bucket: optional start, an ascending set of present symbols, then ranks.
  task automatic push_bucket(int alpha, int max_syms);
    int target, cnt, nranks, rank, pick, near_lim;
    if ($urandom_range(0, 99) < 90) push_item(ACT_START, SYM_W'($urandom), 1'($urandom));
    target = $urandom_range(1, max_syms);
    cnt = 0;
    for (int s = 0; s < alpha; s++) begin
      if ($urandom_range(1, alpha) <= target) begin
        push_item(ACT_APPEND, SYM_W'(s), 1'($urandom_range(0, 1)));
        cnt++;
      end
    end
    // Now and then a symbol outside the alphabet.
    if (alpha <= 255 && $urandom_range(0, 99) < 15)
      push_item(ACT_APPEND, SYM_W'($urandom_range(alpha, 255)), 1'($urandom_range(0, 1)));
    nranks = $urandom_range(1, 3 * cnt + 2);
    near_lim = (cnt - 1 < 7) ? cnt - 1 : 7;
    for (int k = 0; k < nranks; k++) begin
      pick = $urandom_range(0, 99);
      if (cnt == 0 || pick < 8) rank = $urandom_range(cnt, 255);
      else if (pick < 80) rank = $urandom_range(0, near_lim);
      else rank = $urandom_range(0, cnt - 1);
      push_item(ACT_DECODE, SYM_W'(rank), (k == nranks - 1) || ($urandom_range(0, 99) < 5));
    end
    // Occasional noise between buckets.
    if ($urandom_range(0, 99) < 10)
      push_item(2'($urandom_range(0, 3)), SYM_W'($urandom), 1'($urandom));
  endtask

  initial begin : stim_proc
    int alpha;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset alphabet size.
    set_idling(32, 88);
    push_item(ACT_START, 8'd0, 1'b0);
    push_item(ACT_APPEND, 8'd0, 1'b0);
    push_item(ACT_APPEND, 8'd255, 1'b1);
    push_item(ACT_APPEND, 8'd7, 1'b0);
    push_item(ACT_APPEND, 8'd7, 1'b0);   // repeated symbol is stored as given
    push_item(ACT_APPEND, 8'd3, 1'b0);   // out of order is stored as given
    push_item(ACT_DECODE, 8'd0, 1'b0);
    push_item(ACT_DECODE, 8'd4, 1'b0);   // highest valid rank
    push_item(ACT_DECODE, 8'd5, 1'b1);   // rank equal to the count
    push_item(ACT_DECODE, 8'd255, 1'b0); // largest rank, out of range
    push_item(ACT_DECODE, 8'd2, 1'b0);
    push_item(ACT_SPARE, 8'd255, 1'b1);  // spare action, empty result
    push_item(ACT_SPARE, 8'd0, 1'b0);
    push_item(ACT_DECODE, 8'd0, 1'b1);
    push_item(ACT_START, 8'd255, 1'b1);
    push_item(ACT_DECODE, 8'd0, 1'b0);   // empty list
    push_item(ACT_APPEND, 8'd128, 1'b0);
    push_item(ACT_DECODE, 8'd0, 1'b0);   // one-symbol bucket
    push_item(ACT_DECODE, 8'd0, 1'b1);

    // Smallest alphabet: only symbol zero is accepted.
    write_alpha(1);
    push_item(ACT_START, 8'd0, 1'b0);
    push_item(ACT_APPEND, 8'd0, 1'b0);
    push_item(ACT_APPEND, 8'd1, 1'b0);
    push_item(ACT_APPEND, 8'd255, 1'b0);
    push_item(ACT_APPEND, 8'd0, 1'b1);
    push_item(ACT_DECODE, 8'd1, 1'b0);
    push_item(ACT_DECODE, 8'd2, 1'b0);
    push_item(ACT_DECODE, 8'd0, 1'b1);

    // Full alphabet: fill the list to capacity, overflow it, then walk deep ranks.
    write_alpha(256);
    push_item(ACT_START, 8'd0, 1'b0);
    for (int i = 0; i < LIST_DEPTH; i++)
      push_item(ACT_APPEND, SYM_W'($urandom), 1'($urandom));
    push_item(ACT_APPEND, SYM_W'($urandom), 1'b0);
    push_item(ACT_DECODE, 8'd255, 1'b0);
    push_item(ACT_DECODE, 8'd254, 1'b0);
    push_item(ACT_DECODE, 8'd0, 1'b0);
    push_item(ACT_DECODE, 8'd128, 1'b0);
    for (int i = 0; i < 6; i++) push_item(ACT_DECODE, SYM_W'($urandom_range(0, 255)), 1'b0);
    push_item(ACT_DECODE, 8'd255, 1'b1);
    while (items_pushed < 350) push_bucket(256, 24);

    // Mid-size alphabet, sender mostly idle and receiver mostly ready.
    alpha = $urandom_range(2, 255);
    write_alpha(alpha);
    set_idling(88, 32);
    while (items_pushed < 620) push_bucket(alpha, (alpha < 24) ? alpha : 24);

    // No idling; a long receiver hold-off, then a full pause of the sender.
    alpha = $urandom_range(100, 256);
    write_alpha(alpha);
    set_idling(0, 0);
    while (items_pushed < 800) push_bucket(alpha, 20);
    @(negedge clk);
    hold_req = 1'b1;
    drain_all();
    while (items_pushed < 950) push_bucket(alpha, 20);

    drain_all();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("move_to_front_decoder_with_map_top regression: pass");
    end else begin
      $display("move_to_front_decoder_with_map_top regression: fail");
    end
    $finish;
  end

endmodule
